>>> hdl/dcvc_pkg.sv
// shared constants and types for the dominant closed vertex count block
`timescale 1ns / 1ps

package dcvc_pkg;

  // fixed field widths
  localparam int VTX_W       = 10;
  localparam int OUT_TALLY_W = 12;
  localparam int MIN_W       = 10;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_ADDR_W  = 3;

  // default sizing of the tally store
  localparam int DEF_STORE_DEPTH = 1024;
  localparam int DEF_TALLY_MAX   = 4095;

  // generation tag kept with each tally word; a store sweep runs when it wraps
  localparam int EPOCH_W = 6;

  // in-flight writes the memory does not show yet: one pending, one just written
  localparam int FWD_DEPTH = 2;

  // item kinds
  typedef enum logic {
    KIND_ADD    = 1'b0,
    KIND_REPORT = 1'b1
  } kind_t;

  // register word index
  typedef enum logic {
    REG_MIN_TARGET = 1'b0,
    REG_UNUSED     = 1'b1
  } reg_idx_t;

endpackage

>>> hdl/dcvc_fwd_cell.sv
// one cell of the write-forwarding chain: holds one recent tally write
`timescale 1ns / 1ps

module dcvc_fwd_cell #(
  parameter int AW = 10,
  parameter int TW = 12,
  parameter int EW = 6
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          adv,
  // entry handed in from the newer neighbor
  input  logic          ent_in_valid,
  input  logic [AW-1:0] ent_in_addr,
  input  logic [EW-1:0] ent_in_epoch,
  input  logic [TW-1:0] ent_in_tally,
  // entry held here, handed to the older neighbor
  output logic          ent_valid,
  output logic [AW-1:0] ent_addr,
  output logic [EW-1:0] ent_epoch,
  output logic [TW-1:0] ent_tally,
  // lookup of the tally being updated
  input  logic [AW-1:0] look_addr,
  input  logic [EW-1:0] look_epoch,
  input  logic          hit_in,
  input  logic [TW-1:0] hit_tally_in,
  output logic          hit_out,
  output logic [TW-1:0] hit_tally_out
);

  logic own_hit;

  // shift the entry along the chain on every pipeline step
  always_ff @(posedge clk) begin
    if (rst) begin
      ent_valid <= 1'b0;
    end else if (adv) begin
      ent_valid <= ent_in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ent_addr  <= ent_in_addr;
      ent_epoch <= ent_in_epoch;
      ent_tally <= ent_in_tally;
    end
  end

  // this cell is newer than anything behind it, so its match wins
  assign own_hit       = ent_valid && (ent_addr == look_addr) && (ent_epoch == look_epoch);
  assign hit_out       = own_hit || hit_in;
  assign hit_tally_out = own_hit ? ent_tally : hit_tally_in;

endmodule

>>> hdl/dominant_closed_vertex_count.sv
// top level: closed-shape vertex count histogram with running mode
`timescale 1ns / 1ps

// Keys arrive on the input channel (in_valid / in_stall). An add item
// (kind 0) bumps the saturating tally of its vertex count when the shape is
// closed and the count is above the configured minimum; a report item (kind 1)
// yields one result on the output channel (out_valid / out_stall) holding the
// most frequent count (larger count on ties, 0 if none) and its tally, then
// starts a fresh histogram. Adds produce no result.
// One item is taken every cycle while in_stall is low. A report's result
// passes stage 1 and stage 2 into the output register. The tally memory is
// read when an item is taken and written from the chain head; a two-cell
// forwarding chain covers repeated counts in between, so back-to-back keys
// cost nothing. Each tally word carries a generation tag, so a report
// clears the store at once. After reset, and after every 64th report, a
// clearing pass, during which in_stall is high, writes the whole store,
// one word a cycle once stages 1 and 2 have drained (later while that
// report's result is held back). Configuration writes are taken throughout.
// While the output register holds a result that is stalled, adds keep
// flowing; only a following report waits in the pipeline.

module dominant_closed_vertex_count #(
  parameter int STORE_DEPTH = dcvc_pkg::DEF_STORE_DEPTH,
  parameter int TALLY_MAX   = dcvc_pkg::DEF_TALLY_MAX
) (
  input  logic                               clk,
  input  logic                               rst,
  // configuration port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [dcvc_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [dcvc_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [dcvc_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                               pready,
  // key items
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               kind,
  input  logic [dcvc_pkg::VTX_W-1:0]         vertex_count,
  input  logic                               is_closed,
  // result items
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [dcvc_pkg::VTX_W-1:0]         dominant_vertices,
  output logic [dcvc_pkg::OUT_TALLY_W-1:0]   dominant_tally
);

  import dcvc_pkg::*;

  localparam int AW = $clog2(STORE_DEPTH);
  localparam int TW = $clog2(TALLY_MAX + 1);
  localparam int EW = EPOCH_W;
  localparam int MW = EW + TW;

  // configuration
  logic [MIN_W-1:0]  min_target;
  logic              cfg_wr;
  reg_idx_t          cfg_idx;

  // pipeline control
  logic              adv;
  logic              accept;
  logic              in_qual;
  logic [31:0]       vc32;
  logic [AW-1:0]     in_addr;

  // generation tag and clearing pass
  logic [EW-1:0]     epoch;
  logic              sweep_busy;
  logic [AW-1:0]     sweep_cnt;
  logic              sweep_we;

  // tally memory
  logic [MW-1:0]     mem [STORE_DEPTH];
  logic [MW-1:0]     rd_q;
  logic [EW-1:0]     rd_tag;
  logic [TW-1:0]     rd_tally;
  logic              pipe_we;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [MW-1:0]     mem_wdata;

  // stage 1: tally update
  logic              s1_valid;
  logic              s1_report;
  logic              s1_qual;
  logic [AW-1:0]     s1_addr;
  logic [VTX_W-1:0]  s1_vtx;
  logic [EW-1:0]     s1_epoch;
  logic [TW-1:0]     base_tally;
  logic [TW-1:0]     new_tally;

  // stage 2: running best
  logic              s2_valid;
  logic              s2_report;
  logic              s2_qual;
  logic [VTX_W-1:0]  s2_vtx;
  logic [TW-1:0]     s2_tally;
  logic              s2_better;

  logic [VTX_W-1:0]  best_vtx;
  logic [TW-1:0]     best_tally;
  logic [31:0]       best_tally32;

  // forwarding chain wiring
  logic              c_valid [FWD_DEPTH+1];
  logic [AW-1:0]     c_addr  [FWD_DEPTH+1];
  logic [EW-1:0]     c_epoch [FWD_DEPTH+1];
  logic [TW-1:0]     c_tally [FWD_DEPTH+1];
  logic              h_hit   [FWD_DEPTH+1];
  logic [TW-1:0]     h_tally [FWD_DEPTH+1];

  // register port
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      min_target <= '0;
    end else if (cfg_wr && (cfg_idx == REG_MIN_TARGET)) begin
      min_target <= pwdata[MIN_W-1:0];
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_MIN_TARGET: prdata = {{(CFG_DATA_W-MIN_W){1'b0}}, min_target};
      default:        prdata = '0;
    endcase
  end

  // the pipeline only waits when a report meets a stalled full output register
  assign adv      = !(s2_valid && s2_report && out_valid && out_stall);
  assign in_stall = !adv || sweep_busy;
  assign accept   = in_valid && !in_stall;

  // input qualification
  assign vc32    = 32'(vertex_count);
  assign in_addr = vc32[AW-1:0];
  assign in_qual = (kind_t'(kind) == KIND_ADD) && is_closed &&
                   (vertex_count > min_target) && (vc32 < 32'(STORE_DEPTH));

  // generation tag; a wrap starts a clearing pass
  always_ff @(posedge clk) begin
    if (rst) begin
      epoch      <= '0;
      sweep_busy <= 1'b1;
      sweep_cnt  <= '0;
    end else begin
      if (accept && (kind_t'(kind) == KIND_REPORT)) begin
        epoch <= epoch + 1'b1;
        if (epoch == {EW{1'b1}}) begin
          sweep_busy <= 1'b1;
          sweep_cnt  <= '0;
        end
      end
      if (sweep_we) begin
        sweep_cnt <= sweep_cnt + 1'b1;
        if (sweep_cnt == AW'(STORE_DEPTH - 1)) begin
          sweep_busy <= 1'b0;
        end
      end
    end
  end

  // clear only once the in-flight writes have landed
  assign sweep_we = sweep_busy && !s1_valid && !s2_valid;

  // memory write port: pending write from the chain head, or the clearing pass
  assign pipe_we   = adv && c_valid[1];
  assign mem_we    = pipe_we || sweep_we;
  assign mem_waddr = sweep_we ? sweep_cnt : c_addr[1];
  assign mem_wdata = sweep_we ? '0 : {c_epoch[1], c_tally[1]};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (adv) begin
      rd_q <= mem[in_addr];
    end
  end

  assign rd_tag   = rd_q[MW-1:TW];
  assign rd_tally = rd_q[TW-1:0];

  // stage 1 registers
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_report <= (kind_t'(kind) == KIND_REPORT);
      s1_qual   <= in_qual;
      s1_addr   <= in_addr;
      s1_vtx    <= vertex_count;
      s1_epoch  <= epoch;
    end
  end

  // chain entry point: the update made in stage 1
  assign c_valid[0] = s1_valid && s1_qual;
  assign c_addr[0]  = s1_addr;
  assign c_epoch[0] = s1_epoch;
  assign c_tally[0] = new_tally;

  // oldest end of the lookup has no match
  assign h_hit[FWD_DEPTH]   = 1'b0;
  assign h_tally[FWD_DEPTH] = '0;

  for (genvar i = 0; i < FWD_DEPTH; i++) begin : g_fwd
    dcvc_fwd_cell #(
      .AW (AW),
      .TW (TW),
      .EW (EW)
    ) u_cell (
      .clk           (clk),
      .rst           (rst),
      .adv           (adv),
      .ent_in_valid  (c_valid[i]),
      .ent_in_addr   (c_addr[i]),
      .ent_in_epoch  (c_epoch[i]),
      .ent_in_tally  (c_tally[i]),
      .ent_valid     (c_valid[i+1]),
      .ent_addr      (c_addr[i+1]),
      .ent_epoch     (c_epoch[i+1]),
      .ent_tally     (c_tally[i+1]),
      .look_addr     (s1_addr),
      .look_epoch    (s1_epoch),
      .hit_in        (h_hit[i+1]),
      .hit_tally_in  (h_tally[i+1]),
      .hit_out       (h_hit[i]),
      .hit_tally_out (h_tally[i])
    );
  end

  // current tally: newest in-flight write, else memory word of this generation
  always_comb begin
    if (h_hit[0]) begin
      base_tally = h_tally[0];
    end else if (rd_tag == s1_epoch) begin
      base_tally = rd_tally;
    end else begin
      base_tally = '0;
    end
  end

  // saturating increment
  assign new_tally = (base_tally < TW'(TALLY_MAX)) ? base_tally + 1'b1 : base_tally;

  // stage 2 registers
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_report <= s1_report;
      s2_qual   <= s1_qual;
      s2_vtx    <= s1_vtx;
      s2_tally  <= new_tally;
    end
  end

  // higher tally wins, larger vertex count on equal tallies
  assign s2_better = (s2_tally > best_tally) ||
                     ((s2_tally == best_tally) && (s2_vtx > best_vtx));

  always_ff @(posedge clk) begin
    if (rst) begin
      best_vtx   <= '0;
      best_tally <= '0;
    end else if (adv && s2_valid) begin
      if (s2_report) begin
        best_vtx   <= '0;
        best_tally <= '0;
      end else if (s2_qual && s2_better) begin
        best_vtx   <= s2_vtx;
        best_tally <= s2_tally;
      end
    end
  end

  // output register
  assign best_tally32 = 32'(best_tally);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv && s2_valid && s2_report) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s2_valid && s2_report) begin
      dominant_vertices <= best_vtx;
      dominant_tally    <= best_tally32[OUT_TALLY_W-1:0];
    end
  end

  // no key is taken while the store is being cleared
  a_sweep_blocks_input: assert property (@(posedge clk) disable iff (rst)
    sweep_busy |-> in_stall)
    else $error("key taken during clearing pass");

  // clearing pass never collides with a tally write
  a_one_writer: assert property (@(posedge clk) disable iff (rst)
    !(pipe_we && sweep_we))
    else $error("tally write and clearing write in the same cycle");

  // a report leaves an empty running best behind
  a_report_clears_best: assert property (@(posedge clk) disable iff (rst)
    (adv && s2_valid && s2_report) |=> (best_tally == '0 && best_vtx == '0))
    else $error("running best not cleared after report");

  // a result only appears because a report passed stage 2
  a_result_from_report: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(adv && s2_valid && s2_report))
    else $error("result without a report item");

  // running best never goes past the saturation value
  a_best_saturates: assert property (@(posedge clk) disable iff (rst)
    s2_valid |-> (best_tally <= TW'(TALLY_MAX)))
    else $error("running best tally beyond its limit");

endmodule
